/* hdl/chained_hash_table_macros.svh */
// ---------------------------------------------------------------------------
// chained_hash_table assertion macros
// shared property wrappers for the hash table block
// ---------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_MACROS_SVH
`define CHAINED_HASH_TABLE_MACROS_SVH

// checked on every edge outside reset
`define CHT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CHT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/cht_pkg.sv */
// ---------------------------------------------------------------------------
// cht_pkg
// types and constants shared by the chained hash table modules
// ---------------------------------------------------------------------------
package cht_pkg;

	localparam int unsigned KEY_BITS         = 32;
	localparam int unsigned VALUE_PORT_BITS  = 32;
	localparam int unsigned DEF_NUM_BUCKETS  = 8;
	localparam int unsigned DEF_WAYS         = 4;
	localparam int unsigned DEF_VALUE_BITS   = 32;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_REMOVE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_DONE      = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_RD,
		ST_CMP,
		ST_WR
	} state_t;

endpackage

/* hdl/cht_mod_unit.sv */
// ---------------------------------------------------------------------------
// cht_mod_unit
// remainder of the key by the bucket count through a reciprocal multiply
// ---------------------------------------------------------------------------
module cht_mod_unit import cht_pkg::*; #(
	parameter int unsigned DIVISOR = DEF_NUM_BUCKETS,
	parameter int unsigned REM_W   = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [KEY_BITS-1:0] key,
	output logic                done,
	output logic [REM_W-1:0]    rem
);

	// floor((2^KEY_BITS - 1) / DIVISOR): the estimated quotient is low by at most one,
	// so the raw remainder stays below twice the divisor
	localparam logic [KEY_BITS-1:0] RECIP =
		KEY_BITS'(((64'd1 << KEY_BITS) - 64'd1) / 64'(DIVISOR));
	localparam logic [REM_W:0]      DIV_R = (REM_W+1)'(DIVISOR);

	logic [KEY_BITS-1:0]   key_q;
	logic [REM_W:0]        quot_q;
	logic [REM_W:0]        qn_q;
	logic [REM_W-1:0]      rem_q;
	logic [2:0]            step_q;
	logic [2*KEY_BITS-1:0] prod;
	logic [REM_W:0]        diff;

	assign prod = (2*KEY_BITS)'(key_q) * (2*KEY_BITS)'(RECIP);

	// only the low bits matter, the true difference is below 2*DIVISOR
	assign diff = key_q[REM_W:0] - qn_q;

	// step 0: quotient estimate, step 1: quotient times divisor, step 2: correct
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			quot_q <= '0;
			qn_q   <= '0;
			rem_q  <= '0;
			step_q <= '0;
		end else if (start) begin
			key_q  <= key;
			step_q <= 3'b001;
		end else begin
			if (step_q[0]) begin
				quot_q <= prod[KEY_BITS +: (REM_W+1)];
			end
			if (step_q[1]) begin
				qn_q <= quot_q * DIV_R;
			end
			if (step_q[2]) begin
				if (diff >= DIV_R) begin
					rem_q <= REM_W'(diff - DIV_R);
				end else begin
					rem_q <= diff[REM_W-1:0];
				end
			end
			step_q <= {step_q[1:0], 1'b0};
		end
	end

	assign done = (step_q == '0);
	assign rem  = rem_q;

endmodule

/* hdl/cht_slot_mem.sv */
// ---------------------------------------------------------------------------
// cht_slot_mem
// slot store, one write and one registered read a cycle
// ---------------------------------------------------------------------------
module cht_slot_mem import cht_pkg::*; #(
	parameter int unsigned DEPTH  = DEF_NUM_BUCKETS * DEF_WAYS,
	parameter int unsigned ADDR_W = 5,
	parameter int unsigned DATA_W = 1 + KEY_BITS + DEF_VALUE_BITS
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hdl/chained_hash_table.sv */
// ---------------------------------------------------------------------------
// chained_hash_table
// key-value table with bounded chains, bucket = key mod NUM_BUCKETS
// ---------------------------------------------------------------------------
//  channel   dir  tdata                       tuser
//  s_*       in   key, value                  cmd
//  m_*       out  read_value                  hit, status, table_empty
//
//  an item runs from its accept through the bucket remainder (reciprocal
//  multiply, quotient times bucket count, correction), then a read and a
//  compare per way through the slot memory read port, then one write-back;
//  s_tready stays low from the accept until that write-back is done
//  after reset a clearing pass writes all NUM_BUCKETS*WAYS slots, one a
//  cycle, before s_tready rises
//  a new item is taken while a result waits; its write-back holds until
//  the pending result transfer completes
// ---------------------------------------------------------------------------
`include "chained_hash_table_macros.svh"

module chained_hash_table import cht_pkg::*; #(
	parameter int unsigned NUM_BUCKETS = DEF_NUM_BUCKETS,
	parameter int unsigned WAYS        = DEF_WAYS,
	parameter int unsigned VALUE_BITS  = DEF_VALUE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // key[31:0], value[63:32]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // read_value[31:0]
	output logic [3:0]  m_tuser    // hit[0], status[2:1], table_empty[3]
);

	localparam int unsigned SLOTS  = NUM_BUCKETS * WAYS;
	localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
	localparam int unsigned WORD_W = 1 + KEY_BITS + VALUE_BITS;

	state_t                state_q, state_d;
	logic [SLOT_W-1:0]     clr_q;
	cmd_t                  cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [BKT_W-1:0]      bucket_q;
	logic [WAY_W-1:0]      way_q;
	logic                  match_q, free_q;
	logic [WAY_W-1:0]      match_way_q, free_way_q;
	logic [VALUE_BITS-1:0] match_val_q;
	logic [CNT_W-1:0]      count_q, count_d;

	logic                  out_valid_q, hit_q, empty_q;
	logic [31:0]           rdval_q;
	status_t               status_q;

	logic                  accept;
	logic                  mod_done;
	logic [BKT_W-1:0]      mod_rem;
	logic [63:0]           in_val64, match_val64;

	logic                  wr_en, rd_en, out_load;
	logic [SLOT_W-1:0]     wr_addr, rd_addr, match_addr, free_addr;
	logic [WORD_W-1:0]     wr_data, rd_data;
	logic                  rd_valid;
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic                  res_hit;
	status_t               res_status;
	logic [31:0]           res_rd;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	assign in_val64    = 64'(s_tdata[63:32]);
	assign match_val64 = 64'(match_val_q);

	// slot word: valid in the low bit, then key, then value
	assign rd_valid = rd_data[0];
	assign rd_key   = rd_data[KEY_BITS:1];
	assign rd_val   = rd_data[WORD_W-1:KEY_BITS+1];

	assign rd_addr    = SLOT_W'(32'(bucket_q) * WAYS + 32'(way_q));
	assign match_addr = SLOT_W'(32'(bucket_q) * WAYS + 32'(match_way_q));
	assign free_addr  = SLOT_W'(32'(bucket_q) * WAYS + 32'(free_way_q));

	cht_mod_unit #(
		.DIVISOR (NUM_BUCKETS),
		.REM_W   (BKT_W)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (s_tdata[31:0]),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	cht_slot_mem #(
		.DEPTH  (SLOTS),
		.ADDR_W (SLOT_W),
		.DATA_W (WORD_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		wr_en      = 1'b0;
		wr_addr    = clr_q;
		wr_data    = '0;
		rd_en      = 1'b0;
		out_load   = 1'b0;
		res_hit    = 1'b0;
		res_status = STATUS_DONE;
		res_rd     = '0;
		count_d    = count_q;
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				if (clr_q == SLOT_W'(SLOTS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				if (mod_done) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				rd_en   = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (way_q == WAY_W'(WAYS - 1)) begin
					state_d = ST_WR;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_WR: begin
				// hold the write-back until the previous result is gone
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					case (cmd_q)
						CMD_INSERT: begin
							if (match_q) begin
								res_hit = 1'b1;
								wr_en   = 1'b1;
								wr_addr = match_addr;
								wr_data = {val_q, key_q, 1'b1};
							end else if (free_q) begin
								wr_en   = 1'b1;
								wr_addr = free_addr;
								wr_data = {val_q, key_q, 1'b1};
								count_d = count_q + 1'b1;
							end else begin
								res_status = STATUS_FULL;
							end
						end
						CMD_SEARCH: begin
							if (match_q) begin
								res_hit = 1'b1;
								res_rd  = match_val64[31:0];
							end else begin
								res_status = STATUS_NOT_FOUND;
							end
						end
						CMD_REMOVE: begin
							if (match_q) begin
								res_hit = 1'b1;
								wr_en   = 1'b1;
								wr_addr = match_addr;
								wr_data = {match_val_q, key_q, 1'b0};
								if (count_q != '0) begin
									count_d = count_q - 1'b1;
								end
							end else begin
								res_status = STATUS_NOT_FOUND;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cmd_q       <= CMD_INSERT;
			key_q       <= '0;
			val_q       <= '0;
			bucket_q    <= '0;
			way_q       <= '0;
			match_q     <= 1'b0;
			free_q      <= 1'b0;
			match_way_q <= '0;
			free_way_q  <= '0;
			match_val_q <= '0;
			count_q     <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				cmd_q   <= cmd_t'(s_tuser);
				key_q   <= s_tdata[31:0];
				val_q   <= in_val64[VALUE_BITS-1:0];
				way_q   <= '0;
				match_q <= 1'b0;
				free_q  <= 1'b0;
			end
			if (state_q == ST_HASH && mod_done) begin
				bucket_q <= mod_rem;
			end
			// one compare per way; first match and first free way win
			if (state_q == ST_CMP) begin
				if (rd_valid) begin
					if (!match_q && rd_key == key_q) begin
						match_q     <= 1'b1;
						match_way_q <= way_q;
						match_val_q <= rd_val;
					end
				end else if (!free_q) begin
					free_q     <= 1'b1;
					free_way_q <= way_q;
				end
				way_q <= way_q + 1'b1;
			end
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			rdval_q     <= '0;
			status_q    <= STATUS_DONE;
			empty_q     <= 1'b1;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				hit_q       <= res_hit;
				rdval_q     <= res_rd;
				status_q    <= res_status;
				empty_q     <= (count_d == '0);
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = rdval_q;
	assign m_tuser  = {empty_q, status_q, hit_q};

	`CHT_ASSERT_ALWAYS(a_no_accept_in_clear, (state_q == ST_CLEAR) |-> !s_tready, "transfer accepted during clearing pass")
	`CHT_ASSERT(a_count_bound, count_q <= CNT_W'(SLOTS), "entry count above slot count")
	`CHT_ASSERT(a_empty_matches_count, m_tvalid |-> (m_tuser[3] == (count_q == '0)), "table_empty out of step with entry count")
	`CHT_ASSERT(a_hit_means_done, (m_tvalid && m_tuser[0]) |-> (status_q == STATUS_DONE), "hit reported with error status")
	`CHT_ASSERT(a_refuse_only_insert, out_load && res_status == STATUS_FULL |-> (cmd_q == CMD_INSERT && !free_q && !match_q), "bucket full reported with room left")

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// stimulus and checking for chained_hash_table: a behavioral copy of the
// bucketed table predicts each result and the monitor compares it, field by
// field, in arrival order; both stream sides idle and stall at random
// ---------------------------------------------------------------------------
module tb;
	import cht_pkg::*;

	localparam int unsigned    NB         = DEF_NUM_BUCKETS;
	localparam int unsigned    NW         = DEF_WAYS;
	localparam logic [31:0]    STORE_MASK = (DEF_VALUE_BITS >= 32) ? 32'hFFFF_FFFF :
		((32'd1 << DEF_VALUE_BITS) - 32'd1);
	localparam int             POOL_SIZE  = 40;
	localparam int             MAX_GAP    = 13;

	typedef struct packed {
		logic        hit;
		logic [31:0] read_value;
		status_t     status;
		logic        table_empty;
	} ht_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // key[31:0], value[63:32]
	logic [1:0]  s_tuser;   // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // read_value[31:0]
	logic [3:0]  m_tuser;   // hit[0], status[2:1], table_empty[3]

	// predicted table contents
	logic [31:0] bucket_key [NB][NW];
	logic [31:0] bucket_val [NB][NW];
	logic        bucket_used [NB][NW];
	int unsigned entries;

	ht_result_t  pending_results [$];
	int          mismatch_count;
	logic [31:0] key_pool [POOL_SIZE];
	int          items_sent;

	bit tx_steady;
	bit rx_steady;
	int rx_wait;
	int rx_hold;

	chained_hash_table #(
		.NUM_BUCKETS (DEF_NUM_BUCKETS),
		.WAYS        (DEF_WAYS),
		.VALUE_BITS  (DEF_VALUE_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic ht_result_t hash_table_apply(cmd_t op, logic [31:0] key,
		logic [31:0] value);
		ht_result_t  r;
		int unsigned b;
		int          match_way;
		int          free_way;
		b = key % NB;
		match_way = -1;
		free_way = -1;
		r = '0;
		r.status = STATUS_DONE;
		for (int w = 0; w < NW; w++) begin
			if (bucket_used[b][w]) begin
				if (match_way < 0 && bucket_key[b][w] == key)
					match_way = w;
			end else if (free_way < 0) begin
				free_way = w;
			end
		end
		case (op)
			CMD_INSERT: begin
				if (match_way >= 0) begin
					r.hit = 1'b1;
					bucket_val[b][match_way] = value & STORE_MASK;
				end else if (free_way >= 0) begin
					bucket_used[b][free_way] = 1'b1;
					bucket_key[b][free_way] = key;
					bucket_val[b][free_way] = value & STORE_MASK;
					entries++;
				end else begin
					r.status = STATUS_FULL;
				end
			end
			CMD_SEARCH: begin
				if (match_way >= 0) begin
					r.hit = 1'b1;
					r.read_value = bucket_val[b][match_way];
				end else begin
					r.status = STATUS_NOT_FOUND;
				end
			end
			CMD_REMOVE: begin
				if (match_way >= 0) begin
					r.hit = 1'b1;
					bucket_used[b][match_way] = 1'b0;
					if (entries > 0)
						entries--;
				end else begin
					r.status = STATUS_NOT_FOUND;
				end
			end
			default: ;
		endcase
		r.table_empty = (entries == 0);
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// monitor: input transfers feed the prediction, output transfers are checked
	always @(posedge clk) begin
		ht_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				pending_results.push_back(hash_table_apply(cmd_t'(s_tuser),
					s_tdata[31:0], s_tdata[63:32]));
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result expected none actual %0h/%0h", $time,
						m_tuser, m_tdata);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("hit", want.hit, m_tuser[0]);
					check_field("read_value", want.read_value, m_tdata);
					check_field("status", want.status, m_tuser[2:1]);
					check_field("table_empty", want.table_empty, m_tuser[3]);
				end
				rx_wait = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
			end
		end
	end

	// receiver: random stall per result, plus a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready = 1'b0;
				rx_hold--;
			end else if (rx_wait > 0) begin
				m_tready = 1'b0;
				rx_wait--;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic put_request(cmd_t op, logic [31:0] key, logic [31:0] value);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser = op;
		s_tdata = {value, key};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
	endtask

	function automatic cmd_t pick_cmd(int ins_pct, int srch_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < ins_pct)
			return CMD_INSERT;
		else if (roll < ins_pct + srch_pct)
			return CMD_SEARCH;
		return CMD_REMOVE;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 15))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic refill_pool();
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
	endtask

	// removes every key the table holds, so the last result reports empty
	task automatic test_drain_all();
		logic [31:0] held [$];
		for (int b = 0; b < NB; b++)
			for (int w = 0; w < NW; w++)
				if (bucket_used[b][w])
					held.push_back(bucket_key[b][w]);
		foreach (held[i])
			put_request(CMD_REMOVE, held[i], pick_value());
	endtask

	task automatic test_directed();
		// misses on an empty table
		put_request(CMD_SEARCH, 32'd5, 32'hFFFF_FFFF);
		put_request(CMD_REMOVE, 32'd5, 32'd0);
		// key and value extremes, then an update in place
		put_request(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
		put_request(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		put_request(CMD_SEARCH, 32'h0000_0000, 32'd0);
		put_request(CMD_SEARCH, 32'hFFFF_FFFF, 32'd0);
		put_request(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
		put_request(CMD_SEARCH, 32'h0000_0000, 32'd0);
		// fill one bucket with keys differing only in the upper bits
		put_request(CMD_INSERT, 32'd3, 32'hA5A5_5A5A);
		put_request(CMD_INSERT, 32'd11, 32'h5A5A_A5A5);
		put_request(CMD_INSERT, 32'h8000_0003, 32'h1234_5678);
		put_request(CMD_INSERT, 32'hFFFF_FFFB, 32'h8765_4321);
		// bucket full: refused, then a freed slot is reused
		put_request(CMD_INSERT, 32'd19, 32'hDEAD_BEEF);
		put_request(CMD_SEARCH, 32'd19, 32'd0);
		put_request(CMD_REMOVE, 32'd11, 32'd0);
		put_request(CMD_INSERT, 32'd19, 32'hCAFE_F00D);
		put_request(CMD_SEARCH, 32'd19, 32'd0);
		put_request(CMD_SEARCH, 32'h8000_0003, 32'd0);
		// remove miss in a bucket that holds an entry
		put_request(CMD_REMOVE, 32'h7FFF_FFFF, 32'd0);
		test_drain_all();
	endtask

	task automatic test_random_ops(int target);
		int   start;
		int   len;
		int   kind;
		int   phase;
		cmd_t op;
		logic [31:0] key;
		start = items_sent;
		phase = 0;
		refill_pool();
		while (items_sent - start < target) begin
			kind = (phase % 4 == 3) ? $urandom_range(0, 2) : phase % 4;
			len = $urandom_range(40, 80);
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < len; i++) begin
				case (kind)
					0: op = pick_cmd(70, 20);
					1: op = pick_cmd(34, 33);
					default: op = pick_cmd(15, 25);
				endcase
				// mostly pooled keys so that hits and full buckets are common
				if ($urandom_range(0, 15) == 0)
					key = $urandom;
				else
					key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
				put_request(op, key, pick_value());
			end
			if (phase % 6 == 5) begin
				test_drain_all();
				refill_pool();
			end
			phase++;
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// receiver holds off long while the sender keeps offering transfers
	task automatic test_backpressure();
		@(posedge clk);
		rx_hold = 300;
		@(negedge clk);
		tx_steady = 1'b1;
		for (int i = 0; i < 24; i++)
			put_request(($urandom_range(0, 1) == 0) ? CMD_INSERT : CMD_SEARCH,
				key_pool[$urandom_range(0, POOL_SIZE - 1)], pick_value());
		tx_steady = 1'b0;
		test_drain_all();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_INSERT;
		mismatch_count = 0;
		items_sent = 0;
		entries = 0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		rx_wait = 0;
		rx_hold = 0;
		for (int b = 0; b < NB; b++)
			for (int w = 0; w < NW; w++)
				bucket_used[b][w] = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_ops(860);
		test_backpressure();

		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
